@@ src/trv_pkg.sv @@
`default_nettype none

package trv_pkg;

   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 4;
   localparam int STATE_WORDS = 10;
   localparam int IMAGE_BYTES = 40;
   localparam int SECRET_BYTES = 10;
   localparam int IV_OFFSET   = 12;
   localparam int PAD_BYTE    = 37;
   localparam logic [7:0] PAD_VALUE = 8'h70;
   localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;
   localparam logic [LEN_W-1:0] MAX_LEN = 4'd10;

   localparam logic OP_INIT  = 1'b0;
   localparam logic OP_CRYPT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IV_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IV_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LEN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IV_LEN   = 3'd5;

   typedef logic [STATE_WORDS-1:0][31:0] cipher_state_type;
   typedef logic [IMAGE_BYTES-1:0][7:0]  image_type;

   typedef struct packed {
      cipher_state_type state;
      logic [31:0]      z;
   } step_type;

   typedef struct packed {
      logic [DATA_W-1:0]  word;
      logic [COUNT_W-1:0] count;
   } result_type;

   // bits c-64 .. c-33 of a two-word window, upper word first
   function automatic logic [31:0] win64(input logic [63:0] pair, input int c);
      logic [63:0] shifted;
      shifted = pair >> (c - 64);
      return shifted[31:0];
   endfunction

   function automatic logic [31:0] win96(input logic [63:0] pair, input int c);
      logic [63:0] shifted;
      shifted = pair >> (c - 96);
      return shifted[31:0];
   endfunction

   // 32 rounds at once
   function automatic step_type word_step(input cipher_state_type w);
      logic [63:0] p1;
      logic [63:0] p4;
      logic [63:0] p7;
      logic [63:0] p8;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      step_type    r;
      p1 = {w[2], w[1]};
      p4 = {w[5], w[4]};
      p7 = {w[8], w[7]};
      p8 = {w[9], w[8]};
      a = win64(p1, 66) ^ win64(p1, 93);
      b = win64(p4, 69) ^ win64(p4, 84);
      c = win64(p7, 66) ^ win96(p8, 111);
      r.z = a ^ b ^ c;
      a = a ^ (win64(p1, 91) & win64(p1, 92)) ^ win64(p4, 78);
      b = b ^ (win64(p4, 82) & win64(p4, 83)) ^ win64(p7, 87);
      c = c ^ (win96(p8, 109) & win96(p8, 110)) ^ win64(p1, 69);
      r.state = {w[8], w[7], w[6], b, w[4], w[3], a, w[1], w[0], c};
      return r;
   endfunction

   function automatic cipher_state_type load_image(
      input logic [8*SECRET_BYTES-1:0] key,
      input logic [8*SECRET_BYTES-1:0] iv,
      input logic [LEN_W-1:0]          key_len,
      input logic [LEN_W-1:0]          iv_len
   );
      image_type        img;
      logic [LEN_W-1:0] kl;
      logic [LEN_W-1:0] il;
      kl  = (key_len > MAX_LEN) ? MAX_LEN : key_len;
      il  = (iv_len > MAX_LEN) ? MAX_LEN : iv_len;
      img = '0;
      for (int i = 0; i < SECRET_BYTES; i++) begin
         if (i < int'(kl)) begin
            img[i] = key[8*i +: 8];
         end
         if (i < int'(il)) begin
            img[IV_OFFSET + i] = iv[8*i +: 8];
         end
      end
      img[PAD_BYTE] = PAD_VALUE;
      return cipher_state_type'(img);
   endfunction

endpackage

`default_nettype wire

@@ src/trv_req_if.sv @@
`default_nettype none

interface trv_req_if;
   import trv_pkg::*;

   logic               valid;
   logic               ready;
   logic               opcode;
   logic [DATA_W-1:0]  data_word;
   logic [COUNT_W-1:0] byte_count;

   modport source (output valid, output opcode, output data_word, output byte_count,
                   input ready);
   modport sink   (input valid, input opcode, input data_word, input byte_count,
                   output ready);
endinterface

`default_nettype wire

@@ src/trv_rsp_if.sv @@
`default_nettype none

interface trv_rsp_if;
   import trv_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  result_word;
   logic [COUNT_W-1:0] result_count;

   modport source (output valid, output result_word, output result_count, input ready);
   modport sink   (input valid, input result_word, input result_count, output ready);
endinterface

`default_nettype wire

@@ src/trv_csr.sv @@
`default_nettype none

module trv_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [trv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [trv_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output trv_pkg::cipher_state_type             load_state
);
   import trv_pkg::*;

   logic [63:0]      key_low_ff;
   logic [15:0]      key_high_ff;
   logic [63:0]      iv_low_ff;
   logic [15:0]      iv_high_ff;
   logic [LEN_W-1:0] key_len_ff;
   logic [LEN_W-1:0] iv_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         iv_low_ff   <= '0;
         iv_high_ff  <= '0;
         key_len_ff  <= MAX_LEN;
         iv_len_ff   <= MAX_LEN;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_KEY_LOW:  key_low_ff  <= csr_write_data;
            REG_KEY_HIGH: key_high_ff <= csr_write_data[15:0];
            REG_IV_LOW:   iv_low_ff   <= csr_write_data;
            REG_IV_HIGH:  iv_high_ff  <= csr_write_data[15:0];
            REG_KEY_LEN:  key_len_ff  <= csr_write_data[LEN_W-1:0];
            REG_IV_LEN:   iv_len_ff   <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign load_state = load_image({key_high_ff, key_low_ff}, {iv_high_ff, iv_low_ff},
                                  key_len_ff, iv_len_ff);

endmodule

`default_nettype wire

@@ src/trv_core.sv @@
`default_nettype none

module trv_core #(
   parameter int INIT_WORD_STEPS = 36
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   trv_req_if.sink                    req_bus,
   input  wire trv_pkg::cipher_state_type load_state,
   input  wire logic                  out_free,
   output logic                       res_valid,
   output trv_pkg::result_type        res
);
   import trv_pkg::*;

   localparam int CNT_W = $clog2(INIT_WORD_STEPS + 1);

   logic               stage_valid_ff;
   logic               stage_valid_in;
   logic               stage_opcode_ff;
   logic [DATA_W-1:0]  stage_data_ff;
   logic [COUNT_W-1:0] stage_count_ff;
   cipher_state_type   state_ff;
   cipher_state_type   state_in;
   logic [CNT_W-1:0]   init_left_ff;
   logic [CNT_W-1:0]   init_left_in;

   step_type           step;
   logic               is_crypt;
   logic               produces;
   logic               fire;
   logic               req_take;
   logic [COUNT_W-1:0] eff_count;
   logic [DATA_W-1:0]  mask;

   assign step     = word_step(state_ff);
   assign is_crypt = (stage_opcode_ff == OP_CRYPT);
   assign produces = stage_valid_ff && is_crypt && (stage_count_ff != '0);
   assign fire     = stage_valid_ff && (init_left_ff == '0) && (!produces || out_free);
   assign req_bus.ready = !stage_valid_ff || fire;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      eff_count = (stage_count_ff inside {[3'd5:3'd7]}) ? FULL_COUNT : stage_count_ff;
      case (eff_count)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   assign res_valid = fire && produces;
   assign res.word  = (stage_data_ff ^ step.z) & mask;
   assign res.count = eff_count;

   always_comb begin
      stage_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);
      state_in       = state_ff;
      init_left_in   = init_left_ff;
      if (init_left_ff != '0) begin
         state_in     = step.state;
         init_left_in = init_left_ff - 1'b1;
      end else if (fire && !is_crypt) begin
         state_in     = load_state;
         init_left_in = CNT_W'(INIT_WORD_STEPS);
      end else if (fire && produces) begin
         state_in = step.state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         state_ff       <= '0;
         init_left_ff   <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         state_ff       <= state_in;
         init_left_ff   <= init_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_opcode_ff <= req_bus.opcode;
         stage_data_ff   <= req_bus.data_word;
         stage_count_ff  <= req_bus.byte_count;
      end
   end

   a_no_result_during_init: assert property (@(posedge clock) disable iff (reset)
      (init_left_ff != '0) |-> !res_valid)
      else $error("result issued while init steps pending");

   a_init_load_count: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_crypt) |=> (init_left_ff == CNT_W'(INIT_WORD_STEPS)))
      else $error("init transaction did not arm step counter");

   a_init_countdown: assert property (@(posedge clock) disable iff (reset)
      (init_left_ff != '0) |=> (init_left_ff == $past(init_left_ff) - 1'b1))
      else $error("init step counter did not count down");

   a_stall_during_init: assert property (@(posedge clock) disable iff (reset)
      (init_left_ff != '0 && stage_valid_ff) |-> !req_bus.ready)
      else $error("input taken while held transaction waits on init");

endmodule

`default_nettype wire

@@ src/trv_out.sv @@
`default_nettype none

module trv_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_valid,
   input  wire trv_pkg::result_type res,
   output logic                     out_free,
   trv_rsp_if.source                rsp_bus
);
   import trv_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_word  = rsp_data_ff.word;
   assign rsp_bus.result_count = rsp_data_ff.count;

endmodule

`default_nettype wire

@@ src/trivium_stream_cipher_32bit.sv @@
// Trivium stream cipher, 32 keystream bits per cycle while crypts are not stalled.
// req_bus: valid/ready transactions with opcode, data_word, byte_count.
//   opcode 0 loads key and IV from the csr registers and runs the init
//   sequence; it returns nothing. opcode 1 encrypts/decrypts up to four
//   bytes (byte 0 in bits 7:0) and returns one rsp_bus transaction with
//   result_word and result_count; byte_count 0 returns nothing.
// csr_*: write-only registers, index 0 key_low, 1 key_high, 2 iv_low,
//   3 iv_high, 4 key_len, 5 iv_len. Write only while idle.
// A crypt result passes from the input register through the result register.
// Throughput: one crypt transaction per cycle when no init runs and rsp_bus
//   takes results, set by the single word-step unit on the state register.
// Init: after the load the state register makes INIT_WORD_STEPS word steps
//   (36 by default), one per cycle; the transaction behind it waits in the
//   input register, so req_bus.ready drops for that span.
// Reset clears the state to zero and the registers to their defaults; a
//   crypt before any init runs on the all-zero state.
// Receiver stall: the result register holds; one more transaction sits in the
//   input register and then req_bus.ready goes low until rsp_bus drains.
`default_nettype none

module trivium_stream_cipher_32bit #(
   parameter int INIT_WORD_STEPS = 36
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   trv_req_if.sink                               req_bus,
   trv_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_write_en,
   input  wire logic [trv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [trv_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import trv_pkg::*;

   cipher_state_type load_state;
   logic             out_free;
   logic             res_valid;
   result_type       res;

   trv_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .load_state     (load_state)
   );

   trv_core #(
      .INIT_WORD_STEPS (INIT_WORD_STEPS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .load_state (load_state),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   trv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
